### sv/averaged_sensor_divider_convert_assert.svh
// Assertion macros for the averaged sensor divider converter.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef AVERAGED_SENSOR_DIVIDER_CONVERT_ASSERT_SVH
`define AVERAGED_SENSOR_DIVIDER_CONVERT_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define ASDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define ASDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/asdc_pkg.sv
// Shared widths, constants and register index codes for the
// averaged sensor divider converter; no dependencies.
package asdc_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int CONV_W      = 16;
    localparam int PULLUP_W    = 16;
    localparam int PROD_W      = 28;
    localparam int DEN_W       = 13;
    localparam int ITER_W      = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int VOLT_SHIFT  = 12;

    localparam logic [SAMPLE_W-1:0] AVG_CLAMP    = 12'd3511;
    localparam logic [DEN_W-1:0]    FULL_SCALE   = 13'd4096;
    localparam logic [PULLUP_W-1:0] VOLT_SCALE   = 16'd500;
    localparam logic [2:0]          CLAMP_MULT   = 3'd6;
    localparam logic [CONV_W-1:0]   CONV_MAX     = 16'hFFFF;
    localparam logic [PULLUP_W-1:0] PULLUP_RESET = 16'd1000;

    localparam logic MODE_VOLTAGE    = 1'b0;
    localparam logic MODE_RESISTANCE = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SENSE_MODE  = 1'b0,
        REG_PULLUP_OHMS = 1'b1
    } cfg_index_t;

endpackage

### sv/asdc_if.sv
// Request channels of the averaged sensor divider converter.
// Depends on asdc_pkg for the payload widths.
interface asdc_in_if
    import asdc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface asdc_out_if
    import asdc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] average;
    logic [CONV_W-1:0]   converted;

    modport source (output valid, output average, output converted, input ready);
    modport sink   (input valid, input average, input converted, output ready);
endinterface

### sv/averaged_sensor_divider_convert.sv
// Averaged sensor divider converter: windowed ADC average and unit conversion.
// Depends on asdc_pkg, asdc_if.sv and averaged_sensor_divider_convert_assert.svh.
//
// Usage:
//   samples  (sink)   : one 12-bit ADC request per item.
//   results  (source) : one request per item with average and converted value.
//   cfg_we/cfg_index/cfg_data: register writes, only while the block is idle.
// The window lives in a single-port synchronous memory: the oldest entry is
// read on accept, then replaced and the running sum updated in the next cycle.
// Path from accept to results.valid: the update state, the multiply and
// conversion states, then the done state, which loads the output register.
// Resistance mode adds a pass of the shared restoring divider (one quotient
// bit per cycle) unless clamped; during warm-up a divider pass by the fill
// count comes first and gives the average. One item is processed at a time;
// the next sample is taken the cycle after the previous result enters the
// output register, even if not yet taken.
// A stalled receiver holds the output register; the next result waits in
// the done state until it frees up.
// Reset empties the window logically (fill count zero, no memory sweep),
// sets voltage mode and a 1000 ohm pull-up.
module averaged_sensor_divider_convert
    import asdc_pkg::*;
#(
    parameter int WINDOW_LOG2 = 5
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    asdc_in_if.sink                samples,
    asdc_out_if.source             results
);

    localparam int WIN_SIZE = 1 << WINDOW_LOG2;
    localparam int SUM_W    = SAMPLE_W + WINDOW_LOG2;
    localparam int FILL_W   = WINDOW_LOG2 + 1;
    localparam int SUM_PAD  = PROD_W - SUM_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_UPD  = 6'b000010,
        S_DIV  = 6'b000100,
        S_MUL  = 6'b001000,
        S_CONV = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    logic [SAMPLE_W-1:0] mem [WIN_SIZE];

    state_t                 state_reg, state_next;
    logic [SAMPLE_W-1:0]    sample_reg, sample_next;
    logic [SAMPLE_W-1:0]    rdata_reg;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [WINDOW_LOG2-1:0] slot_reg, slot_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [SAMPLE_W-1:0]    avg_reg, avg_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [DEN_W-1:0]       den_reg, den_next;
    logic [DEN_W-1:0]       rem_reg, rem_next;
    logic [PROD_W-1:0]      numq_reg, numq_next;
    logic [ITER_W-1:0]      iter_reg, iter_next;
    logic                   div_conv_reg, div_conv_next;
    logic [CONV_W-1:0]      conv_reg, conv_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]    out_avg_reg, out_avg_next;
    logic [CONV_W-1:0]      out_conv_reg, out_conv_next;
    logic                   mode_reg;
    logic [PULLUP_W-1:0]    pullup_reg;

    logic                   accept;
    logic                   out_load;
    logic [SAMPLE_W-1:0]    old_val;
    logic [SUM_W-1:0]       sum_upd;
    logic [DEN_W:0]         div_shift;
    logic [DEN_W:0]         div_diff;
    logic                   div_ge;
    logic [PULLUP_W+2:0]    clamp_val;
    logic [PULLUP_W-1:0]    mul_b;

    assign accept   = samples.valid && samples.ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || results.ready);

    assign samples.ready     = (state_reg == S_IDLE);
    assign results.valid     = out_valid_reg;
    assign results.average   = out_avg_reg;
    assign results.converted = out_conv_reg;

    // Entries beyond the fill count hold no valid sample and count as zero.
    assign old_val   = fill_reg[WINDOW_LOG2] ? rdata_reg : '0;
    assign sum_upd   = sum_reg - SUM_W'(old_val) + SUM_W'(sample_reg);
    assign div_shift = {rem_reg, numq_reg[PROD_W-1]};
    assign div_ge    = (div_shift >= {1'b0, den_reg});
    assign div_diff  = div_shift - {1'b0, den_reg};
    assign clamp_val = (PULLUP_W+3)'(pullup_reg) * (PULLUP_W+3)'(CLAMP_MULT);
    assign mul_b     = (mode_reg == MODE_RESISTANCE) ? pullup_reg : VOLT_SCALE;

    always_comb
    begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        sum_next       = sum_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        avg_next       = avg_reg;
        prod_next      = prod_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        numq_next      = numq_reg;
        iter_next      = iter_reg;
        div_conv_next  = div_conv_reg;
        conv_next      = conv_reg;
        out_valid_next = out_valid_reg;
        out_avg_next   = out_avg_reg;
        out_conv_next  = out_conv_reg;

        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sample_next = samples.sample;
                    state_next  = S_UPD;
                end
            end
            S_UPD:
            begin
                sum_next  = sum_upd;
                slot_next = slot_reg + 1'b1;
                if (!fill_reg[WINDOW_LOG2])
                begin
                    fill_next     = fill_reg + 1'b1;
                    numq_next     = {sum_upd, {SUM_PAD{1'b0}}};
                    rem_next      = '0;
                    den_next      = DEN_W'(fill_reg + 1'b1);
                    iter_next     = ITER_W'(SUM_W);
                    div_conv_next = 1'b0;
                    state_next    = S_DIV;
                end
                else
                begin
                    avg_next   = sum_upd[SUM_W-1:WINDOW_LOG2];
                    state_next = S_MUL;
                end
            end
            S_DIV:
            begin
                rem_next  = div_ge ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
                numq_next = {numq_reg[PROD_W-2:0], div_ge};
                iter_next = iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1))
                begin
                    if (div_conv_reg)
                    begin
                        conv_next  = (|numq_next[PROD_W-1:CONV_W]) ? CONV_MAX
                                                                   : numq_next[CONV_W-1:0];
                        state_next = S_DONE;
                    end
                    else
                    begin
                        avg_next   = numq_next[SAMPLE_W-1:0];
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(avg_reg) * PROD_W'(mul_b);
                den_next   = FULL_SCALE - DEN_W'(avg_reg);
                state_next = S_CONV;
            end
            S_CONV:
            begin
                if (mode_reg == MODE_VOLTAGE)
                begin
                    conv_next  = prod_reg[VOLT_SHIFT +: CONV_W];
                    state_next = S_DONE;
                end
                else if (avg_reg > AVG_CLAMP)
                begin
                    conv_next  = (|clamp_val[PULLUP_W+2:PULLUP_W]) ? CONV_MAX
                                                                   : clamp_val[CONV_W-1:0];
                    state_next = S_DONE;
                end
                else
                begin
                    numq_next     = prod_reg;
                    rem_next      = '0;
                    iter_next     = ITER_W'(PROD_W);
                    div_conv_next = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_avg_next   = avg_reg;
                    out_conv_next  = conv_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_VOLTAGE;
            pullup_reg    <= PULLUP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    REG_SENSE_MODE:  mode_reg   <= cfg_data[0];
                    REG_PULLUP_OHMS: pullup_reg <= cfg_data[PULLUP_W-1:0];
                    default:         mode_reg   <= mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        avg_reg      <= avg_next;
        prod_reg     <= prod_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        numq_reg     <= numq_next;
        iter_reg     <= iter_next;
        div_conv_reg <= div_conv_next;
        conv_reg     <= conv_next;
        out_avg_reg  <= out_avg_next;
        out_conv_reg <= out_conv_next;
    end

    // Window memory: read the oldest entry on accept, replace it in the next cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_UPD)
        begin
            mem[slot_reg] <= sample_reg;
        end
        if (accept)
        begin
            rdata_reg <= mem[slot_reg];
        end
    end

`include "averaged_sensor_divider_convert_assert.svh"

    `ASDC_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FILL_W'(WIN_SIZE), "fill count beyond window")
    `ASDC_ASSERT_NEXT(a_avg_quot_fits, (state_reg == S_DIV) && (iter_reg == ITER_W'(1)) && !div_conv_reg, numq_reg[PROD_W-1:SAMPLE_W] == '0, "warm-up average out of range")
    `ASDC_ASSERT_NEXT(a_handoff, out_load, out_valid_reg && (state_reg == S_IDLE), "result not handed to output register")

endmodule
